// ===== design/cmp_pkg.sv =====
// Shared types and constants for the CoAP message parser.
package cmp_pkg;

    // Byte classes.
    localparam logic [2:0] CLS_HEADER   = 3'd0;
    localparam logic [2:0] CLS_TOKEN    = 3'd1;
    localparam logic [2:0] CLS_OPT_HDR  = 3'd2;
    localparam logic [2:0] CLS_OPT_VAL  = 3'd3;
    localparam logic [2:0] CLS_MARKER   = 3'd4;
    localparam logic [2:0] CLS_PAYLOAD  = 3'd5;
    localparam logic [2:0] CLS_SKIP     = 3'd6;

    // Status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_TKL       = 3'd2;
    localparam logic [2:0] ST_DELTA15   = 3'd3;
    localparam logic [2:0] ST_LEN15     = 3'd4;
    localparam logic [2:0] ST_TOO_MANY  = 3'd5;
    localparam logic [2:0] ST_TRUNC     = 3'd6;

    localparam logic [7:0] PAYLOAD_MARKER   = 8'hFF;
    localparam logic [3:0] NIB_EXT1         = 4'd13;
    localparam logic [3:0] NIB_RESERVED     = 4'd15;
    localparam logic [3:0] TKL_MAX          = 4'd8;
    localparam logic [16:0] EXT1_OFFSET     = 17'd13;
    localparam logic [16:0] EXT2_OFFSET     = 17'd269;
    localparam logic [7:0] OPTION_LIMIT_RST = 8'd16;

    typedef enum logic [7:0] {
        PH_HEADER    = 8'b0000_0001,
        PH_TOKEN     = 8'b0000_0010,
        PH_OPT_HDR   = 8'b0000_0100,
        PH_DELTA_EXT = 8'b0000_1000,
        PH_LEN_EXT   = 8'b0001_0000,
        PH_VALUE     = 8'b0010_0000,
        PH_PAYLOAD   = 8'b0100_0000,
        PH_SKIP      = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [2:0]  byte_class;
        logic [7:0]  echo_byte;
        logic [1:0]  version;
        logic [1:0]  pkt_type;
        logic [3:0]  token_length;
        logic [7:0]  code;
        logic [15:0] message_id;
        logic [15:0] option_num;
        logic [16:0] option_length;
        logic        option_ready;
        logic [2:0]  status;
        logic        message_end;
    } cmp_result_t;

endpackage

// ===== design/cmp_parse_core.sv =====
// Parser state registers and the per-byte next-state and result logic.
module cmp_parse_core
    import cmp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  option_limit,
    input  logic        in_fire,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    output cmp_result_t res
);

    phase_t      phase_reg, phase_next;
    logic [1:0]  fbc_reg, fbc_next;
    logic [1:0]  version_reg, version_next;
    logic [1:0]  type_reg, type_next;
    logic [3:0]  tkl_reg, tkl_next;
    logic [7:0]  code_reg, code_next;
    logic [15:0] mid_reg, mid_next;
    logic [3:0]  tok_rem_reg, tok_rem_next;
    logic [3:0]  delta_nib_reg, delta_nib_next;
    logic [3:0]  len_nib_reg, len_nib_next;
    logic [7:0]  ext_acc_reg, ext_acc_next;
    logic [15:0] num_acc_reg, num_acc_next;
    logic [16:0] val_rem_reg, val_rem_next;
    logic [16:0] cur_len_reg, cur_len_next;
    logic [7:0]  opt_cnt_reg, opt_cnt_next;
    logic [2:0]  err_reg, err_next;

    logic [2:0]  cls;
    logic        ready;
    logic        raise_en;
    logic [2:0]  raise_code;
    logic        delta_done;
    logic [16:0] delta_val;
    logic        len_done;
    logic [16:0] len_val;
    logic        ext_done;
    logic [16:0] ext_val;
    logic [3:0]  ext_nib;
    logic [2:0]  final_err;

    always_comb
    begin
        phase_next     = phase_reg;
        fbc_next       = fbc_reg;
        version_next   = version_reg;
        type_next      = type_reg;
        tkl_next       = tkl_reg;
        code_next      = code_reg;
        mid_next       = mid_reg;
        tok_rem_next   = tok_rem_reg;
        delta_nib_next = delta_nib_reg;
        len_nib_next   = len_nib_reg;
        ext_acc_next   = ext_acc_reg;
        num_acc_next   = num_acc_reg;
        val_rem_next   = val_rem_reg;
        cur_len_next   = cur_len_reg;
        opt_cnt_next   = opt_cnt_reg;
        err_next       = err_reg;
        cls            = CLS_SKIP;
        ready          = 1'b0;
        raise_en       = 1'b0;
        raise_code     = ST_OK;
        delta_done     = 1'b0;
        delta_val      = '0;
        len_done       = 1'b0;
        len_val        = '0;
        ext_done       = 1'b0;
        ext_val        = '0;
        ext_nib        = (phase_reg == PH_DELTA_EXT) ? delta_nib_reg : len_nib_reg;

        case (phase_reg)
            PH_HEADER:
            begin
                cls = CLS_HEADER;
                case (fbc_reg)
                    2'd0:
                    begin
                        version_next = in_byte[7:6];
                        type_next    = in_byte[5:4];
                        tkl_next     = in_byte[3:0];
                    end
                    2'd1:    code_next = in_byte;
                    2'd2:    mid_next  = {in_byte, 8'h00};
                    default: mid_next  = {mid_reg[15:8], in_byte};
                endcase
                if (fbc_reg != 2'd3)
                begin
                    fbc_next = fbc_reg + 2'd1;
                end
                else
                begin
                    fbc_next = 2'd0;
                    if (tkl_reg > TKL_MAX)
                    begin
                        raise_en   = 1'b1;
                        raise_code = ST_TKL;
                    end
                    else if (tkl_reg != 4'd0)
                    begin
                        tok_rem_next = tkl_reg;
                        phase_next   = PH_TOKEN;
                    end
                    else
                    begin
                        phase_next = PH_OPT_HDR;
                    end
                end
            end
            PH_TOKEN:
            begin
                cls          = CLS_TOKEN;
                tok_rem_next = tok_rem_reg - 4'd1;
                if (tok_rem_next == 4'd0)
                    phase_next = PH_OPT_HDR;
            end
            PH_OPT_HDR:
            begin
                if (in_byte == PAYLOAD_MARKER)
                begin
                    cls = CLS_MARKER;
                    if (in_last)
                    begin
                        raise_en   = 1'b1;
                        raise_code = ST_TRUNC;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
                else
                begin
                    cls            = CLS_OPT_HDR;
                    delta_nib_next = in_byte[7:4];
                    len_nib_next   = in_byte[3:0];
                    if (in_byte[7:4] == NIB_RESERVED)
                    begin
                        raise_en   = 1'b1;
                        raise_code = ST_DELTA15;
                    end
                    else if (in_byte[3:0] == NIB_RESERVED)
                    begin
                        raise_en   = 1'b1;
                        raise_code = ST_LEN15;
                    end
                    else if (in_byte[7:4] >= NIB_EXT1)
                    begin
                        phase_next   = PH_DELTA_EXT;
                        fbc_next     = 2'd0;
                        ext_acc_next = 8'd0;
                    end
                    else
                    begin
                        delta_done = 1'b1;
                        delta_val  = {13'd0, in_byte[7:4]};
                    end
                end
            end
            PH_DELTA_EXT, PH_LEN_EXT:
            begin
                cls = CLS_OPT_HDR;
                if (ext_nib == NIB_EXT1)
                begin
                    ext_val  = {9'd0, in_byte} + EXT1_OFFSET;
                    ext_done = 1'b1;
                end
                else if (fbc_reg == 2'd0)
                begin
                    ext_acc_next = in_byte;
                    fbc_next     = 2'd1;
                end
                else
                begin
                    ext_val  = {1'b0, ext_acc_reg, in_byte} + EXT2_OFFSET;
                    fbc_next = 2'd0;
                    ext_done = 1'b1;
                end
                if (ext_done)
                begin
                    if (phase_reg == PH_DELTA_EXT)
                    begin
                        delta_done = 1'b1;
                        delta_val  = ext_val;
                    end
                    else
                    begin
                        len_done = 1'b1;
                        len_val  = ext_val;
                    end
                end
            end
            PH_VALUE:
            begin
                cls          = CLS_OPT_VAL;
                val_rem_next = val_rem_reg - 17'd1;
                if (val_rem_next == 17'd0)
                    phase_next = PH_OPT_HDR;
            end
            PH_PAYLOAD:
            begin
                cls = CLS_PAYLOAD;
            end
            default:
            begin
                cls = CLS_SKIP;
            end
        endcase

        // The option number wraps at 16 bits, so only the low half of the delta matters.
        if (delta_done)
        begin
            num_acc_next = num_acc_reg + delta_val[15:0];
            if (len_nib_next >= NIB_EXT1)
            begin
                phase_next   = PH_LEN_EXT;
                fbc_next     = 2'd0;
                ext_acc_next = 8'd0;
            end
            else
            begin
                len_done = 1'b1;
                len_val  = {13'd0, len_nib_next};
            end
        end

        if (len_done)
        begin
            cur_len_next = len_val;
            ready        = 1'b1;
            if (({1'b0, opt_cnt_reg} + 9'd1) >= {1'b0, option_limit})
            begin
                raise_en   = 1'b1;
                raise_code = ST_TOO_MANY;
            end
            else
            begin
                opt_cnt_next = opt_cnt_reg + 8'd1;
                val_rem_next = len_val;
                phase_next   = (len_val != 17'd0) ? PH_VALUE : PH_OPT_HDR;
            end
        end

        if (raise_en)
        begin
            phase_next = PH_SKIP;
            if (err_reg == ST_OK)
                err_next = raise_code;
        end

        // A message that ends part way through a field is reported on its last beat.
        final_err = err_next;
        if (in_last && err_next == ST_OK)
        begin
            if (phase_next == PH_HEADER)
                final_err = ST_SHORT;
            else if (phase_next == PH_TOKEN)
                final_err = ST_TKL;
            else if (phase_next == PH_DELTA_EXT || phase_next == PH_LEN_EXT ||
                     phase_next == PH_VALUE)
                final_err = ST_TRUNC;
        end

        res.byte_class    = cls;
        res.echo_byte     = in_byte;
        res.version       = version_next;
        res.pkt_type      = type_next;
        res.token_length  = tkl_next;
        res.code          = code_next;
        res.message_id    = mid_next;
        res.option_num    = num_acc_next;
        res.option_length = cur_len_next;
        res.option_ready  = ready;
        res.status        = final_err;
        res.message_end   = in_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            fbc_reg       <= '0;
            version_reg   <= '0;
            type_reg      <= '0;
            tkl_reg       <= '0;
            code_reg      <= '0;
            mid_reg       <= '0;
            tok_rem_reg   <= '0;
            delta_nib_reg <= '0;
            len_nib_reg   <= '0;
            ext_acc_reg   <= '0;
            num_acc_reg   <= '0;
            val_rem_reg   <= '0;
            cur_len_reg   <= '0;
            opt_cnt_reg   <= '0;
            err_reg       <= ST_OK;
        end
        else if (in_fire)
        begin
            if (in_last)
            begin
                phase_reg     <= PH_HEADER;
                fbc_reg       <= '0;
                version_reg   <= '0;
                type_reg      <= '0;
                tkl_reg       <= '0;
                code_reg      <= '0;
                mid_reg       <= '0;
                tok_rem_reg   <= '0;
                delta_nib_reg <= '0;
                len_nib_reg   <= '0;
                ext_acc_reg   <= '0;
                num_acc_reg   <= '0;
                val_rem_reg   <= '0;
                cur_len_reg   <= '0;
                opt_cnt_reg   <= '0;
                err_reg       <= ST_OK;
            end
            else
            begin
                phase_reg     <= phase_next;
                fbc_reg       <= fbc_next;
                version_reg   <= version_next;
                type_reg      <= type_next;
                tkl_reg       <= tkl_next;
                code_reg      <= code_next;
                mid_reg       <= mid_next;
                tok_rem_reg   <= tok_rem_next;
                delta_nib_reg <= delta_nib_next;
                len_nib_reg   <= len_nib_next;
                ext_acc_reg   <= ext_acc_next;
                num_acc_reg   <= num_acc_next;
                val_rem_reg   <= val_rem_next;
                cur_len_reg   <= cur_len_next;
                opt_cnt_reg   <= opt_cnt_next;
                err_reg       <= err_next;
            end
        end
    end

    a_ready_on_opt_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        res.option_ready |-> res.byte_class == CLS_OPT_HDR)
        else $error("option_ready outside an option header byte");

    a_skip_has_error: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && phase_reg == PH_SKIP) |-> (res.byte_class == CLS_SKIP &&
                                               res.status != ST_OK))
        else $error("skipped byte without an error status");

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !in_last && err_reg != ST_OK) |=> err_reg == $past(err_reg))
        else $error("error code changed within a message");

endmodule

// ===== design/cmp_out_stage.sv =====
// Output register that holds one result beat until the downstream side takes it.
module cmp_out_stage
    import cmp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  cmp_result_t in_res,
    output logic        out_valid,
    input  logic        out_ready,
    output cmp_result_t out_res
);

    logic        valid_reg;
    cmp_result_t res_reg;

    // A new beat may enter while the register is empty or when the held one leaves in the same cycle.
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            res_reg <= in_res;
    end

    a_fire_gives_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> valid_reg)
        else $error("accepted beat did not reach the output register");

    a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !out_ready) |-> !in_ready)
        else $error("input accepted while the output register is full");

    a_idle_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && out_ready && !in_valid) |=> !valid_reg)
        else $error("output register kept a beat that was taken");

endmodule

// ===== design/coap_message_parser.sv =====
// Top level of the CoAP message parser: stream ports, option limit register, parser, output stage.
// The result for each accepted byte is computed combinationally and held in the output register for m_axis.
// Throughput: one byte per cycle unless output stalls; parser state updates once per beat.
// s_axis_tready falls only while the output register holds a beat that is not being taken.
// Reset (rst_n low, asynchronous): the parser returns to the header phase with all
// fields and counters zero, the output register empties, and option_limit becomes 16.
module coap_message_parser
    import cmp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,    // option_limit
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // echo_byte[7:0], version[9:8], pkt_type[11:10], token_length[15:12], code[23:16],
    // message_id[39:24], option_num[55:40], option_length[72:56], option_ready[73],
    // status[76:74], zero fill[79:77]
    output logic [79:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser,   // byte_class[2:0]
    output logic        m_axis_tlast
);

    logic [7:0]  option_limit_reg;
    logic        in_fire;
    cmp_result_t step_res;
    cmp_result_t out_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            option_limit_reg <= OPTION_LIMIT_RST;
        else if (cfg_wr_en)
            option_limit_reg <= cfg_wr_data;
    end

    assign in_fire = s_axis_tvalid && s_axis_tready;

    cmp_parse_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .option_limit (option_limit_reg),
        .in_fire      (in_fire),
        .in_byte      (s_axis_tdata),
        .in_last      (s_axis_tlast),
        .res          (step_res)
    );

    cmp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_res    (step_res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {3'b000,
                           out_res.status,
                           out_res.option_ready,
                           out_res.option_length,
                           out_res.option_num,
                           out_res.message_id,
                           out_res.code,
                           out_res.token_length,
                           out_res.pkt_type,
                           out_res.version,
                           out_res.echo_byte};
    assign m_axis_tuser = out_res.byte_class;
    assign m_axis_tlast = out_res.message_end;

endmodule

// ===== test/coap_message_parser_test.sv =====
// Self-checking testbench for the CoAP message parser: directed and random messages.
module coap_message_parser_test
    import cmp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [3:0] NIB_EXT2 = 4'd14;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = 8'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    coap_message_parser i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    cmp_result_t decoded_due[$];
    int unsigned mismatches = 0;
    int unsigned bytes_sent = 0;
    logic        idle_off = 1'b0;

    // Parser state as seen by the checker.
    logic [7:0]  opt_limit;
    phase_t      ph;
    logic [1:0]  field_cnt;
    logic [1:0]  hdr_version;
    logic [1:0]  hdr_type;
    logic [3:0]  hdr_tkl;
    logic [7:0]  hdr_code;
    logic [15:0] hdr_mid;
    logic [3:0]  token_left;
    logic [3:0]  delta_nib;
    logic [3:0]  len_nib;
    logic [7:0]  ext_hi;
    logic [15:0] opt_number;
    logic [16:0] value_left;
    logic [16:0] opt_len;
    logic [7:0]  opt_count;
    logic [2:0]  err;
    logic        opt_done;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void clear_message();
        ph = PH_HEADER;
        field_cnt = '0;
        hdr_version = '0;
        hdr_type = '0;
        hdr_tkl = '0;
        hdr_code = '0;
        hdr_mid = '0;
        token_left = '0;
        delta_nib = '0;
        len_nib = '0;
        ext_hi = '0;
        opt_number = '0;
        value_left = '0;
        opt_len = '0;
        opt_count = '0;
        err = ST_OK;
    endfunction

    function automatic void raise_error(input logic [2:0] code);
        if (err == ST_OK)
            err = code;
        ph = PH_SKIP;
    endfunction

    function automatic void complete_option();
        opt_done = 1'b1;
        if (9'(opt_count) + 9'd1 >= 9'(opt_limit))
        begin
            raise_error(ST_TOO_MANY);
            return;
        end
        opt_count = opt_count + 8'd1;
        value_left = opt_len;
        ph = (opt_len != 0) ? PH_VALUE : PH_OPT_HDR;
    endfunction

    function automatic void apply_delta(input logic [16:0] delta);
        opt_number = opt_number + delta[15:0];
        if (len_nib >= NIB_EXT1)
        begin
            ph = PH_LEN_EXT;
            field_cnt = '0;
            ext_hi = '0;
        end
        else
        begin
            opt_len = 17'(len_nib);
            complete_option();
        end
    endfunction

    // Advances the parser state by one byte and returns the beat it should emit.
    function automatic cmp_result_t decode_byte(input logic [7:0] b, input logic last);
        cmp_result_t r;
        logic [2:0]  cls;
        phase_t      start;
        logic [3:0]  nib;
        logic [16:0] val;
        logic        done;
        cls = CLS_SKIP;
        start = ph;
        opt_done = 1'b0;
        case (start)
            PH_HEADER:
            begin
                cls = CLS_HEADER;
                case (field_cnt)
                    2'd0:
                    begin
                        hdr_version = b[7:6];
                        hdr_type = b[5:4];
                        hdr_tkl = b[3:0];
                    end
                    2'd1: hdr_code = b;
                    2'd2: hdr_mid = {b, 8'h00};
                    default: hdr_mid = {hdr_mid[15:8], b};
                endcase
                if (field_cnt != 2'd3)
                    field_cnt = field_cnt + 2'd1;
                else
                begin
                    field_cnt = '0;
                    if (hdr_tkl > TKL_MAX)
                        raise_error(ST_TKL);
                    else if (hdr_tkl != 0)
                    begin
                        token_left = hdr_tkl;
                        ph = PH_TOKEN;
                    end
                    else
                        ph = PH_OPT_HDR;
                end
            end
            PH_TOKEN:
            begin
                cls = CLS_TOKEN;
                token_left = token_left - 4'd1;
                if (token_left == 0)
                    ph = PH_OPT_HDR;
            end
            PH_OPT_HDR:
            begin
                if (b == PAYLOAD_MARKER)
                begin
                    cls = CLS_MARKER;
                    if (last)
                        raise_error(ST_TRUNC);
                    else
                        ph = PH_PAYLOAD;
                end
                else
                begin
                    cls = CLS_OPT_HDR;
                    delta_nib = b[7:4];
                    len_nib = b[3:0];
                    if (delta_nib == NIB_RESERVED)
                        raise_error(ST_DELTA15);
                    else if (len_nib == NIB_RESERVED)
                        raise_error(ST_LEN15);
                    else if (delta_nib >= NIB_EXT1)
                    begin
                        ph = PH_DELTA_EXT;
                        field_cnt = '0;
                        ext_hi = '0;
                    end
                    else
                        apply_delta(17'(delta_nib));
                end
            end
            PH_DELTA_EXT, PH_LEN_EXT:
            begin
                cls = CLS_OPT_HDR;
                nib = (start == PH_DELTA_EXT) ? delta_nib : len_nib;
                val = '0;
                done = 1'b0;
                if (nib == NIB_EXT1)
                begin
                    val = 17'(b) + EXT1_OFFSET;
                    done = 1'b1;
                end
                else if (field_cnt == 0)
                begin
                    ext_hi = b;
                    field_cnt = 2'd1;
                end
                else
                begin
                    val = {1'b0, ext_hi, b} + EXT2_OFFSET;
                    field_cnt = '0;
                    done = 1'b1;
                end
                if (done)
                begin
                    if (start == PH_DELTA_EXT)
                        apply_delta(val);
                    else
                    begin
                        opt_len = val;
                        complete_option();
                    end
                end
            end
            PH_VALUE:
            begin
                cls = CLS_OPT_VAL;
                value_left = value_left - 17'd1;
                if (value_left == 0)
                    ph = PH_OPT_HDR;
            end
            PH_PAYLOAD: cls = CLS_PAYLOAD;
            default: cls = CLS_SKIP;
        endcase

        // Ending in the middle of a field is only reported if nothing failed earlier.
        if (last && err == ST_OK)
        begin
            if (ph == PH_HEADER)
                err = ST_SHORT;
            else if (ph == PH_TOKEN)
                err = ST_TKL;
            else if (ph == PH_DELTA_EXT || ph == PH_LEN_EXT || ph == PH_VALUE)
                err = ST_TRUNC;
        end

        r.byte_class = cls;
        r.echo_byte = b;
        r.version = hdr_version;
        r.pkt_type = hdr_type;
        r.token_length = hdr_tkl;
        r.code = hdr_code;
        r.message_id = hdr_mid;
        r.option_num = opt_number;
        r.option_length = opt_len;
        r.option_ready = opt_done;
        r.status = err;
        r.message_end = last;
        if (last)
            clear_message();
        return r;
    endfunction

    task automatic check_field(input string name, input logic [16:0] want,
                               input logic [16:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Checks every beat leaving the parser against the oldest prediction.
    always @(posedge clk)
    begin : check_beats
        cmp_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (decoded_due.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, got echo %0h class %0d",
                         $time, m_axis_tdata[7:0], m_axis_tuser);
                mismatches++;
            end
            else
            begin
                want = decoded_due.pop_front();
                check_field("byte_class", 17'(want.byte_class), 17'(m_axis_tuser));
                check_field("echo_byte", 17'(want.echo_byte), 17'(m_axis_tdata[7:0]));
                check_field("version", 17'(want.version), 17'(m_axis_tdata[9:8]));
                check_field("pkt_type", 17'(want.pkt_type), 17'(m_axis_tdata[11:10]));
                check_field("token_length", 17'(want.token_length),
                            17'(m_axis_tdata[15:12]));
                check_field("code", 17'(want.code), 17'(m_axis_tdata[23:16]));
                check_field("message_id", 17'(want.message_id), 17'(m_axis_tdata[39:24]));
                check_field("option_num", 17'(want.option_num),
                            17'(m_axis_tdata[55:40]));
                check_field("option_length", want.option_length, m_axis_tdata[72:56]);
                check_field("option_ready", 17'(want.option_ready), 17'(m_axis_tdata[73]));
                check_field("status", 17'(want.status), 17'(m_axis_tdata[76:74]));
                check_field("zero fill", 17'd0, 17'(m_axis_tdata[79:77]));
                check_field("message_end", 17'(want.message_end), 17'(m_axis_tlast));
            end
        end
    end

    // Downstream side: a random stall before each beat, none while idle_off is set.
    initial
    begin : drain_output
        int unsigned stall;
        forever
        begin
            stall = idle_off ? 0 : $urandom_range(0, 9);
            if (stall != 0)
            begin
                @(negedge clk);
                m_axis_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    // tvalid is left high after a beat so the next one can follow directly.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        gap = idle_off ? 0 : $urandom_range(0, 9);
        @(negedge clk);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        decoded_due.push_back(decode_byte(b, last));
        bytes_sent++;
    endtask

    task automatic send_message(input logic [7:0] msg[$]);
        foreach (msg[i])
            send_byte(msg[i], i == msg.size() - 1);
    endtask

    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (decoded_due.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic set_option_limit(input logic [7:0] limit);
        drain();
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= limit;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        opt_limit = limit;
    endtask

    function automatic logic [3:0] span_nibble(input int unsigned v);
        if (v < 13)
            return 4'(v);
        return (v < 269) ? NIB_EXT1 : NIB_EXT2;
    endfunction

    function automatic void push_extension(ref logic [7:0] msg[$], input int unsigned v);
        if (v >= 269)
        begin
            msg.push_back(8'((v - 269) >> 8));
            msg.push_back(8'(v - 269));
        end
        else if (v >= 13)
            msg.push_back(8'(v - 13));
    endfunction

    function automatic void push_option(ref logic [7:0] msg[$], input int unsigned delta,
                                        input int unsigned len);
        msg.push_back({span_nibble(delta), span_nibble(len)});
        push_extension(msg, delta);
        push_extension(msg, len);
        repeat (len) msg.push_back(8'($urandom));
    endfunction

    task automatic test_header();
        send_message('{8'h40});
        send_message('{8'hFF, 8'hFF, 8'hFF});
        send_message('{8'h70, 8'hFF, 8'hFF, 8'hFF});
        send_message('{8'h00, 8'h00, 8'h00, 8'h00});
        send_message('{8'hCF, 8'h45, 8'h12, 8'h34, 8'h00});
        send_message('{8'h69, 8'h01, 8'h00, 8'h01, 8'hAA});
    endtask

    task automatic test_token();
        send_message('{8'h48, 8'h01, 8'hBE, 8'hEF, 8'h11, 8'h22, 8'h33, 8'h44,
                       8'h55, 8'h66, 8'h77, 8'h88});
        send_message('{8'h44, 8'h02, 8'h00, 8'h07, 8'hAA, 8'hBB});
    endtask

    task automatic test_options();
        logic [7:0] msg[$];
        // One-byte delta, two-byte delta that wraps the option number, one-byte length.
        msg = '{8'h40, 8'h01, 8'h00, 8'h01, 8'hD0, 8'h00, 8'hE1, 8'hFF, 8'hFF, 8'h5A,
                8'h1D, 8'h00};
        repeat (13) msg.push_back(8'($urandom));
        send_message(msg);
        send_message('{8'h40, 8'h01, 8'h00, 8'h02, 8'hF0, 8'h00});
        send_message('{8'h40, 8'h01, 8'h00, 8'h03, 8'h2F, 8'h00});
        // Longest possible length, cut off after a few value bytes.
        send_message('{8'h40, 8'h01, 8'h00, 8'h04, 8'h0E, 8'hFF, 8'hFF, 8'h01, 8'h02});
        send_message('{8'h40, 8'h01, 8'h00, 8'h05, 8'hE0, 8'h12});
        send_message('{8'h40, 8'h01, 8'h00, 8'h06, 8'h3D, 8'h07});
        msg = '{8'h40, 8'h02, 8'h00, 8'h07, 8'h0E, 8'h00, 8'h00};
        repeat (269) msg.push_back(8'($urandom));
        send_message(msg);
    endtask

    task automatic test_payload();
        send_message('{8'h40, 8'h45, 8'h00, 8'h08, 8'h11, 8'h77, 8'hFF, 8'hFF, 8'h00});
        send_message('{8'h40, 8'h45, 8'h00, 8'h09, 8'hFF});
        send_message('{8'h40, 8'h45, 8'h00, 8'h0A, 8'h01, 8'hFF});
    endtask

    task automatic test_option_limit();
        logic [7:0] msg[$];
        set_option_limit(8'd1);
        send_message('{8'h40, 8'h01, 8'h00, 8'h01, 8'h10, 8'h00});
        set_option_limit(8'd255);
        msg = '{8'h40, 8'h01, 8'h00, 8'h02};
        repeat (256) msg.push_back(8'h00);
        send_message(msg);
        set_option_limit(8'd3);
        send_message('{8'h40, 8'h01, 8'h00, 8'h03, 8'h10, 8'h10, 8'h10, 8'h10});
        set_option_limit(OPTION_LIMIT_RST);
    endtask

    task automatic send_random_message();
        logic [7:0]  msg[$];
        logic [3:0]  tkl;
        int unsigned n_opts;
        int unsigned len;
        int unsigned pick;
        tkl = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(9, 15)) :
                                             4'($urandom_range(0, 8));
        msg = '{{2'($urandom), 2'($urandom), tkl}, 8'($urandom), 8'($urandom),
                8'($urandom)};
        repeat (tkl) msg.push_back(8'($urandom));
        n_opts = $urandom_range(0, 6);
        repeat (n_opts)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                // A reserved nibble in either position.
                if ($urandom_range(0, 1) == 0)
                    msg.push_back({NIB_RESERVED, 4'($urandom_range(0, 14))});
                else
                    msg.push_back({4'($urandom_range(0, 14)), NIB_RESERVED});
            end
            else
            begin
                pick = $urandom_range(0, 99);
                len = (pick < 75) ? $urandom_range(0, 12) :
                      (pick < 99) ? $urandom_range(13, 30) : $urandom_range(269, 275);
                pick = $urandom_range(0, 19);
                push_option(msg, (pick < 13) ? $urandom_range(0, 12) :
                                 (pick < 18) ? $urandom_range(13, 268) :
                                               $urandom_range(269, 65804), len);
            end
        end
        pick = $urandom_range(0, 9);
        if (pick < 5)
        begin
            msg.push_back(PAYLOAD_MARKER);
            repeat ($urandom_range(1, 8)) msg.push_back(8'($urandom));
        end
        else if (pick == 5)
            msg.push_back(PAYLOAD_MARKER);
        if ($urandom_range(0, 7) == 0)
            msg = msg[0:$urandom_range(0, msg.size() - 1)];
        send_message(msg);
    endtask

    task automatic test_random();
        logic [7:0]  noise[$];
        int unsigned target;
        int unsigned cfg_mark;
        int unsigned pick;
        target = bytes_sent + 150;
        cfg_mark = bytes_sent;
        while (bytes_sent < target)
        begin
            idle_off = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 4) == 0)
            begin
                noise = {};
                repeat ($urandom_range(1, 10)) noise.push_back(8'($urandom));
                send_message(noise);
            end
            else
                send_random_message();
            if (bytes_sent - cfg_mark >= 40)
            begin
                pick = $urandom_range(0, 4);
                set_option_limit(pick == 0 ? 8'd1 : pick == 1 ? 8'd255 :
                                 pick == 2 ? 8'($urandom_range(2, 6)) :
                                 pick == 3 ? OPTION_LIMIT_RST : 8'($urandom_range(1, 255)));
                cfg_mark = bytes_sent;
            end
        end
        idle_off = 1'b0;
    endtask

    initial
    begin
        #(2_000_000);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        opt_limit = OPTION_LIMIT_RST;
        opt_done = 1'b0;
        clear_message();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_header();
        test_token();
        test_options();
        test_payload();
        test_option_limit();
        test_random();
        drain();
        repeat (4) @(posedge clk);

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
